[rtl/ges_pkg.sv]
`default_nettype none

package ges_pkg;

  // Default table depth.
  localparam int NUM_PROCS_DEF = 32;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_PEND    = 2'd1,
    CMD_STATE   = 2'd2,
    CMD_RESCHED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PS_FREE  = 2'd0,
    PS_CURR  = 2'd1,
    PS_READY = 2'd2,
    PS_WAIT  = 2'd3
  } proc_state_t;

  // One row of the process table.
  typedef struct packed {
    proc_state_t state;
    logic [6:0]  prio;
    logic [6:0]  pend;
    logic [7:0]  ticks;
    logic [7:0]  quantum;
  } entry_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_DISPATCH,
    FSM_ITEM_WB,
    FSM_LEFT_WB,
    FSM_CHK,
    FSM_CHK_WAIT,
    FSM_UPD_START,
    FSM_UPD,
    FSM_UPD_WAIT,
    FSM_SW_DECIDE,
    FSM_SW_OLD_WB,
    FSM_SW_NEW_RD,
    FSM_SW_NEW_WB,
    FSM_DONE
  } fsm_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_RD_ID,
    OP_WR_ID,
    OP_RD_RUN,
    OP_WR_LEFT,
    OP_CHK_RD,
    OP_UPD_START,
    OP_UPD_RD,
    OP_WR_DEMOTE,
    OP_RD_BEST,
    OP_WR_PROMOTE,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_t item_cmd;
    logic scan_last;
    logic need_switch;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/goodness_epoch_scheduler_unit.sv]
`default_nettype none

// Channel   Handshake            Beat contents
// input     in_valid / in_stall  cmd, proc_id, proc_state, prio_value, ticks_value,
//                                quantum_value, preempt_left
// output    out_valid/out_stall  next_proc, switched, new_epoch, tick_budget
//
// A write beat (load, pending priority, state) updates its row before its result.
// A reschedule makes two passes over the table memory, which has one read and one
// write port, reading one row per cycle in each pass, and takes extra steps when
// the running process changes.
// Reset (rst, synchronous) clears the valid bit of every row at once, so the table
// reads as all free and zero after reset, and selects entry 0.
// The input is stalled from acceptance until the result is loaded into the output
// register; a result waiting behind out_stall holds the block in its final step.

module goodness_epoch_scheduler_unit
  import ges_pkg::*;
#(
  parameter int NUM_PROCS = NUM_PROCS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [4:0] proc_id,
  input  logic [1:0] proc_state,
  input  logic [6:0] prio_value,
  input  logic [7:0] ticks_value,
  input  logic [7:0] quantum_value,
  input  logic [7:0] preempt_left,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] next_proc,
  output logic       switched,
  output logic       new_epoch,
  output logic [7:0] tick_budget
);

  // The controller sequences each beat as one datapath operation per cycle; the
  // datapath holds the process table, the scan pipeline and the result register.
  ctl_cmd_t   ctl;
  dp_status_t status;

  ges_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctl      (ctl)
  );

  // A reschedule first writes the leftover ticks back, then scans for any runnable
  // entry with goodness, then scans again to refresh (on a new epoch) and pick.
  ges_datapath #(
    .NUM_PROCS (NUM_PROCS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .status        (status),
    .cmd           (cmd),
    .proc_id       (proc_id),
    .proc_state    (proc_state),
    .prio_value    (prio_value),
    .ticks_value   (ticks_value),
    .quantum_value (quantum_value),
    .preempt_left  (preempt_left),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .next_proc     (next_proc),
    .switched      (switched),
    .new_epoch     (new_epoch),
    .tick_budget   (tick_budget)
  );

endmodule

`default_nettype wire

[rtl/ges_ctrl.sv]
`default_nettype none

module ges_ctrl
  import ges_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctl_cmd_t   ctl
);

  fsm_t state;
  fsm_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (in_valid) state_next = FSM_DISPATCH;
      end
      FSM_DISPATCH: begin
        case (status.item_cmd)
          CMD_LOAD:    state_next = FSM_DONE;
          CMD_RESCHED: state_next = FSM_LEFT_WB;
          default:     state_next = FSM_ITEM_WB;
        endcase
      end
      FSM_ITEM_WB:   state_next = FSM_DONE;
      FSM_LEFT_WB:   state_next = FSM_CHK;
      FSM_CHK: begin
        if (status.scan_last) state_next = FSM_CHK_WAIT;
      end
      FSM_CHK_WAIT:  state_next = FSM_UPD_START;
      FSM_UPD_START: state_next = FSM_UPD;
      FSM_UPD: begin
        if (status.scan_last) state_next = FSM_UPD_WAIT;
      end
      FSM_UPD_WAIT:  state_next = FSM_SW_DECIDE;
      FSM_SW_DECIDE: begin
        state_next = status.need_switch ? FSM_SW_OLD_WB : FSM_DONE;
      end
      FSM_SW_OLD_WB: state_next = FSM_SW_NEW_RD;
      FSM_SW_NEW_RD: state_next = FSM_SW_NEW_WB;
      FSM_SW_NEW_WB: state_next = FSM_DONE;
      FSM_DONE: begin
        if (status.out_free) state_next = FSM_IDLE;
      end
      default:       state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != FSM_IDLE);
    ctl.op   = OP_NONE;
    case (state)
      FSM_IDLE: begin
        if (in_valid) ctl.op = OP_LATCH;
      end
      FSM_DISPATCH: begin
        case (status.item_cmd)
          CMD_LOAD:    ctl.op = OP_WR_ID;
          CMD_RESCHED: ctl.op = OP_RD_RUN;
          default:     ctl.op = OP_RD_ID;
        endcase
      end
      FSM_ITEM_WB:   ctl.op = OP_WR_ID;
      FSM_LEFT_WB:   ctl.op = OP_WR_LEFT;
      FSM_CHK:       ctl.op = OP_CHK_RD;
      FSM_UPD_START: ctl.op = OP_UPD_START;
      FSM_UPD:       ctl.op = OP_UPD_RD;
      FSM_SW_DECIDE: ctl.op = OP_RD_RUN;
      FSM_SW_OLD_WB: ctl.op = OP_WR_DEMOTE;
      FSM_SW_NEW_RD: ctl.op = OP_RD_BEST;
      FSM_SW_NEW_WB: ctl.op = OP_WR_PROMOTE;
      FSM_DONE: begin
        if (status.out_free) ctl.op = OP_FINISH;
      end
      default:       ctl.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/ges_datapath.sv]
`default_nettype none

module ges_datapath
  import ges_pkg::*;
#(
  parameter int NUM_PROCS = NUM_PROCS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  ctl_cmd_t   ctl,
  output dp_status_t status,
  input  logic [1:0] cmd,
  input  logic [4:0] proc_id,
  input  logic [1:0] proc_state,
  input  logic [6:0] prio_value,
  input  logic [7:0] ticks_value,
  input  logic [7:0] quantum_value,
  input  logic [7:0] preempt_left,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] next_proc,
  output logic       switched,
  output logic       new_epoch,
  output logic [7:0] tick_budget
);

  localparam int IDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

  // Latched item.
  cmd_t       cmd_q;
  logic [4:0] id_q;
  logic [1:0] st_q;
  logic [6:0] prio_q;
  logic [7:0] ticks_q;
  logic [7:0] quant_q;
  logic [7:0] left_q;

  logic [IDX_W-1:0] running;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] d_idx;
  logic             d_chk;
  logic             d_upd;
  logic             any_good;
  logic             epoch;
  logic             sw;
  logic [IDX_W-1:0] best;
  logic [8:0]       best_g;
  logic [7:0]       best_ticks;

  // Process table with one valid bit per row; an unwritten row reads as zero.
  entry_t               mem [NUM_PROCS];
  logic [NUM_PROCS-1:0] vld;
  entry_t               rd_row;
  logic                 rd_vld;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_row;

  logic [31:0]      id_wide;
  logic [31:0]      run_wide;
  logic             id_ok;
  logic [IDX_W-1:0] id_idx;
  logic             scan_last;

  entry_t     cur;
  entry_t     refr;
  entry_t     scan_e;
  logic [8:0] half_sum;
  logic [7:0] q_new;
  logic       do_refresh;
  logic       runnable;
  logic       good;
  logic [8:0] g;

  assign id_wide   = 32'(id_q);
  assign run_wide  = 32'(running);
  assign id_ok     = (id_wide < 32'(NUM_PROCS));
  assign id_idx    = id_wide[IDX_W-1:0];
  assign scan_last = (idx == IDX_W'(NUM_PROCS - 1));

  assign status.item_cmd    = cmd_q;
  assign status.scan_last   = scan_last;
  assign status.need_switch = (best != running);
  assign status.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (ctl.op == OP_LATCH) begin
      cmd_q   <= cmd_t'(cmd);
      id_q    <= proc_id;
      st_q    <= proc_state;
      prio_q  <= prio_value;
      ticks_q <= ticks_value;
      quant_q <= quantum_value;
      left_q  <= preempt_left;
    end
  end

  // Read port.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (ctl.op)
      OP_RD_ID: begin
        rd_en   = id_ok;
        rd_addr = id_idx;
      end
      OP_RD_RUN: begin
        rd_en   = 1'b1;
        rd_addr = running;
      end
      OP_RD_BEST: begin
        rd_en   = 1'b1;
        rd_addr = best;
      end
      OP_CHK_RD, OP_UPD_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  assign cur = rd_vld ? rd_row : '0;

  // Epoch refresh of the row just read.
  always_comb begin
    half_sum = 9'(cur.ticks >> 1) + 9'(cur.pend);
    if (cur.ticks == cur.quantum || cur.ticks == 8'd0) begin
      q_new = 8'(cur.pend);
    end else if (half_sum > 9'd255) begin
      q_new = 8'hFF;
    end else begin
      q_new = half_sum[7:0];
    end
    refr         = cur;
    refr.quantum = q_new;
    refr.prio    = cur.pend;
    refr.ticks   = q_new;
  end

  assign do_refresh = d_upd && epoch && (cur.state != PS_FREE);
  assign scan_e     = do_refresh ? refr : cur;
  assign runnable   = (scan_e.state == PS_CURR) || (scan_e.state == PS_READY);
  assign good       = (d_idx != '0) && (scan_e.ticks != 8'd0) && runnable;
  assign g          = 9'(scan_e.ticks) + 9'(scan_e.prio);

  // Write port.
  always_comb begin
    wr_en   = do_refresh;
    wr_addr = d_idx;
    wr_row  = refr;
    case (ctl.op)
      OP_WR_ID: begin
        wr_en   = id_ok;
        wr_addr = id_idx;
        wr_row  = cur;
        case (cmd_q)
          CMD_LOAD: begin
            wr_row.state   = proc_state_t'(st_q);
            wr_row.prio    = prio_q;
            wr_row.pend    = prio_q;
            wr_row.ticks   = ticks_q;
            wr_row.quantum = quant_q;
          end
          CMD_PEND: wr_row.pend  = prio_q;
          default:  wr_row.state = proc_state_t'(st_q);
        endcase
      end
      OP_WR_LEFT: begin
        wr_en        = 1'b1;
        wr_addr      = running;
        wr_row       = cur;
        wr_row.ticks = left_q;
      end
      OP_WR_DEMOTE: begin
        wr_en        = 1'b1;
        wr_addr      = running;
        wr_row       = cur;
        wr_row.state = (cur.state == PS_CURR) ? PS_READY : cur.state;
      end
      OP_WR_PROMOTE: begin
        wr_en        = 1'b1;
        wr_addr      = best;
        wr_row       = cur;
        wr_row.state = PS_CURR;
      end
      default: wr_en = do_refresh;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    d_idx <= idx;
    if (d_upd && d_idx == '0) begin
      best_ticks <= scan_e.ticks;
    end else if (d_upd && good && g > best_g) begin
      best_ticks <= scan_e.ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= '0;
      idx       <= '0;
      d_chk     <= 1'b0;
      d_upd     <= 1'b0;
      any_good  <= 1'b0;
      epoch     <= 1'b0;
      sw        <= 1'b0;
      best      <= '0;
      best_g    <= '0;
      out_valid <= 1'b0;
    end else begin
      d_chk <= (ctl.op == OP_CHK_RD);
      d_upd <= (ctl.op == OP_UPD_RD);
      case (ctl.op)
        OP_LATCH: begin
          epoch <= 1'b0;
          sw    <= 1'b0;
        end
        OP_WR_LEFT: begin
          idx      <= '0;
          any_good <= 1'b0;
        end
        OP_CHK_RD, OP_UPD_RD: begin
          if (!scan_last) idx <= idx + 1'b1;
        end
        OP_UPD_START: begin
          idx    <= '0;
          epoch  <= !any_good;
          best   <= '0;
          best_g <= '0;
        end
        OP_WR_PROMOTE: begin
          running <= best;
          sw      <= 1'b1;
        end
        default: begin
        end
      endcase
      if (d_chk && good) begin
        any_good <= 1'b1;
      end
      if (d_upd && good && g > best_g) begin
        best   <= d_idx;
        best_g <= g;
      end
      if (ctl.op == OP_FINISH) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_FINISH) begin
      next_proc   <= run_wide[4:0];
      switched    <= sw;
      new_epoch   <= epoch;
      tick_budget <= (cmd_q == CMD_RESCHED) ? best_ticks : 8'd0;
    end
  end

`ifndef SYNTHESIS
  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_FINISH) |=> out_valid)
    else $error("result register not loaded after finish");

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (32'(wr_addr) < 32'(NUM_PROCS)))
    else $error("table write beyond its depth");

  a_promote_differs: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_WR_PROMOTE) |-> (best != running))
    else $error("switch issued to the running process");

  a_no_write_in_pick: assert property (@(posedge clk) disable iff (rst)
    (d_upd && !epoch) |-> !wr_en)
    else $error("table written during a pick scan without an epoch");
`endif

endmodule

`default_nettype wire

[sim/goodness_epoch_scheduler_unit_tb.sv]
`default_nettype none

// Testbench for the goodness/epoch scheduler.
//
// A directed table runs first. It covers the empty table after reset, the
// widest field values, ties in goodness, the fall-back to the null process,
// free entries being skipped by the epoch, a tick count equal to the quantum,
// and several entries marked current at once. Random beats follow. Every
// accepted input beat is passed through a local model of the process table,
// and the decision that it returns is queued. Each result beat taken from the
// block is compared, field by field, with the oldest queued decision.
module goodness_epoch_scheduler_unit_tb;
  import ges_pkg::*;

  localparam int NPROC       = NUM_PROCS_DEF;
  localparam int RANDOM_BEATS = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIR_ROWS     = 21;

  // One input beat, one field per port.
  typedef struct packed {
    cmd_t        op;
    logic [4:0]  id;
    proc_state_t st;
    logic [6:0]  prio;
    logic [7:0]  ticks;
    logic [7:0]  quantum;
    logic [7:0]  left;
  } beat_t;

  // One result beat.
  typedef struct packed {
    logic [4:0] next_proc;
    logic       switched;
    logic       new_epoch;
    logic [7:0] tick_budget;
  } decision_t;

  // A row of the directed table. Where fixed is set, the result is typed in
  // and is used instead of the model's answer.
  typedef struct packed {
    beat_t     beat;
    logic      fixed;
    decision_t want;
  } stim_row_t;

  localparam decision_t IDLE_RES  = '{5'd0, 1'b0, 1'b0, 8'd0};
  localparam decision_t EPOCH_RES = '{5'd0, 1'b0, 1'b1, 8'd0};

  // The directed walk. Comments give the point of each reschedule.
  stim_row_t dir_rows [DIR_ROWS] = '{
    // Empty table: a new epoch with nothing to refresh, and the null process stays.
    '{'{CMD_RESCHED, 5'd0,  PS_FREE,  7'd0,   8'd0,   8'd0,   8'd0},   1'b1, EPOCH_RES},
    // Writes after reset report the null process and nothing else.
    '{'{CMD_LOAD,    5'd31, PS_READY, 7'd127, 8'd255, 8'd255, 8'd255}, 1'b1, IDLE_RES},
    '{'{CMD_LOAD,    5'd0,  PS_CURR,  7'd0,   8'd0,   8'd0,   8'd0},   1'b1, IDLE_RES},
    '{'{CMD_LOAD,    5'd1,  PS_READY, 7'd99,  8'd10,  8'd20,  8'd0},   1'b1, IDLE_RES},
    // The highest goodness wins and the null process is put back to ready.
    '{'{CMD_RESCHED, 5'd0,  PS_FREE,  7'd0,   8'd0,   8'd0,   8'd255}, 1'b0, IDLE_RES},
    '{'{CMD_PEND,    5'd31, PS_FREE,  7'd0,   8'd0,   8'd0,   8'd0},   1'b0, IDLE_RES},
    '{'{CMD_STATE,   5'd1,  PS_WAIT,  7'd0,   8'd0,   8'd0,   8'd0},   1'b0, IDLE_RES},
    // Nothing runnable is left with ticks, so an epoch runs and entry 0 is chosen.
    '{'{CMD_RESCHED, 5'd0,  PS_FREE,  7'd0,   8'd0,   8'd0,   8'd0},   1'b0, IDLE_RES},
    '{'{CMD_STATE,   5'd1,  PS_READY, 7'd0,   8'd0,   8'd0,   8'd0},   1'b0, IDLE_RES},
    '{'{CMD_RESCHED, 5'd0,  PS_FREE,  7'd0,   8'd0,   8'd0,   8'd200}, 1'b0, IDLE_RES},
    // A waiting entry with a part-used quantum, and one whose ticks equal its quantum.
    '{'{CMD_LOAD,    5'd5,  PS_WAIT,  7'd127, 8'd255, 8'd1,   8'd0},   1'b0, IDLE_RES},
    '{'{CMD_LOAD,    5'd7,  PS_WAIT,  7'd3,   8'd50,  8'd50,  8'd0},   1'b0, IDLE_RES},
    '{'{CMD_RESCHED, 5'd0,  PS_FREE,  7'd0,   8'd0,   8'd0,   8'd0},   1'b0, IDLE_RES},
    // Free entries are left alone by the epoch.
    '{'{CMD_STATE,   5'd5,  PS_FREE,  7'd0,   8'd0,   8'd0,   8'd0},   1'b0, IDLE_RES},
    '{'{CMD_LOAD,    5'd2,  PS_FREE,  7'd50,  8'd100, 8'd30,  8'd0},   1'b0, IDLE_RES},
    // A second entry already marked current.
    '{'{CMD_LOAD,    5'd3,  PS_CURR,  7'd10,  8'd5,   8'd5,   8'd0},   1'b0, IDLE_RES},
    '{'{CMD_RESCHED, 5'd0,  PS_FREE,  7'd0,   8'd0,   8'd0,   8'd7},   1'b0, IDLE_RES},
    // Equal goodness: the lower index must win.
    '{'{CMD_LOAD,    5'd6,  PS_READY, 7'd127, 8'd255, 8'd0,   8'd0},   1'b0, IDLE_RES},
    '{'{CMD_LOAD,    5'd4,  PS_READY, 7'd127, 8'd255, 8'd0,   8'd0},   1'b0, IDLE_RES},
    '{'{CMD_RESCHED, 5'd0,  PS_FREE,  7'd0,   8'd0,   8'd0,   8'd0},   1'b0, IDLE_RES},
    '{'{CMD_RESCHED, 5'd31, PS_WAIT,  7'd127, 8'd255, 8'd255, 8'd255}, 1'b0, IDLE_RES}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] cmd = 2'd0;
  logic [4:0] proc_id = 5'd0;
  logic [1:0] proc_state = 2'd0;
  logic [6:0] prio_value = 7'd0;
  logic [7:0] ticks_value = 8'd0;
  logic [7:0] quantum_value = 8'd0;
  logic [7:0] preempt_left = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] next_proc;
  logic       switched;
  logic       new_epoch;
  logic [7:0] tick_budget;

  goodness_epoch_scheduler_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .proc_id      (proc_id),
    .proc_state   (proc_state),
    .prio_value   (prio_value),
    .ticks_value  (ticks_value),
    .quantum_value(quantum_value),
    .preempt_left (preempt_left),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .next_proc    (next_proc),
    .switched     (switched),
    .new_epoch    (new_epoch),
    .tick_budget  (tick_budget)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The model's copy of the process table and of the running process.
  entry_t     proc_tbl [NPROC];
  logic [4:0] sched_running;

  // Decisions still owed by the block, oldest first.
  decision_t  due_decisions [$];
  int         err_count = 0;

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic bit is_runnable(input int i);
    return proc_tbl[i].state == PS_CURR || proc_tbl[i].state == PS_READY;
  endfunction

  // The null process, and any entry with its ticks used up, count as zero.
  function automatic int unsigned goodness(input int i);
    if (i == 0 || proc_tbl[i].ticks == 8'd0) return 0;
    return int'(proc_tbl[i].ticks) + int'(proc_tbl[i].prio);
  endfunction

  // Applies one accepted beat to the model table and returns the decision
  // that the block has to report for it.
  function automatic decision_t sched_decide(input beat_t b);
    decision_t   r;
    bit          any_good;
    int unsigned t;
    int unsigned q;
    int unsigned best;
    int unsigned best_g;
    r = '0;
    if (b.op != CMD_RESCHED) begin
      case (b.op)
        CMD_LOAD: proc_tbl[b.id] = '{b.st, b.prio, b.prio, b.ticks, b.quantum};
        CMD_PEND: proc_tbl[b.id].pend = b.prio;
        default:  proc_tbl[b.id].state = b.st;
      endcase
      r.next_proc = sched_running;
      return r;
    end
    // The outgoing process gives back what it had left.
    proc_tbl[sched_running].ticks = b.left;
    any_good = 1'b0;
    for (int i = 0; i < NPROC; i++)
      if (is_runnable(i) && goodness(i) > 0) any_good = 1'b1;
    r.new_epoch = !any_good;
    if (!any_good) begin
      // Refill every live entry; half of any unspent part of a quantum is
      // carried over into the next one.
      for (int i = 0; i < NPROC; i++) begin
        if (proc_tbl[i].state != PS_FREE) begin
          t = proc_tbl[i].ticks;
          if (t == proc_tbl[i].quantum || t == 0) q = proc_tbl[i].pend;
          else q = (t >> 1) + proc_tbl[i].pend;
          if (q > 255) q = 255;
          proc_tbl[i].quantum = q[7:0];
          proc_tbl[i].prio    = proc_tbl[i].pend;
          proc_tbl[i].ticks   = q[7:0];
        end
      end
    end
    best   = 0;
    best_g = 0;
    for (int i = 0; i < NPROC; i++) begin
      if (is_runnable(i) && goodness(i) > best_g) begin
        best_g = goodness(i);
        best   = i;
      end
    end
    if (best[4:0] != sched_running) begin
      if (proc_tbl[sched_running].state == PS_CURR)
        proc_tbl[sched_running].state = PS_READY;
      proc_tbl[best].state = PS_CURR;
      sched_running = best[4:0];
      r.switched = 1'b1;
    end
    r.next_proc   = sched_running;
    r.tick_budget = proc_tbl[sched_running].ticks;
    return r;
  endfunction

  // Random beats lean towards the cases that matter: plenty of reschedules,
  // often with nothing left over so that epochs come round, and ticks that
  // sometimes match the quantum exactly.
  function automatic beat_t random_beat();
    beat_t b;
    int    sel;
    sel = $urandom_range(0, 99);
    b.op = (sel < 30) ? CMD_LOAD : (sel < 45) ? CMD_PEND :
           (sel < 62) ? CMD_STATE : CMD_RESCHED;
    b.id   = 5'($urandom_range(0, 31));
    b.st   = proc_state_t'($urandom_range(0, 3));
    b.prio = 7'($urandom_range(0, 127));
    b.ticks = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    b.quantum = ($urandom_range(0, 4) == 0) ? b.ticks : 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 9);
    if (sel < 4) b.left = 8'd0;
    else if (sel < 7) b.left = 8'($urandom_range(1, 15));
    else b.left = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Offers one beat and returns at the edge at which it is taken. The beat
  // is driven at the current edge and held, unchanged, while in_stall is high.
  task automatic offer_beat(input beat_t b, input bit fixed, input decision_t want);
    decision_t got;
    in_valid      <= 1'b1;
    cmd           <= b.op;
    proc_id       <= b.id;
    proc_state    <= b.st;
    prio_value    <= b.prio;
    ticks_value   <= b.ticks;
    quantum_value <= b.quantum;
    preempt_left  <= b.left;
    do @(posedge clk); while (in_stall);
    got = sched_decide(b);
    due_decisions.push_back(fixed ? want : got);
  endtask

  // Sender: directed rows, then random beats, in bursts with random gaps.
  // A gap of zero lets some bursts run straight into the next one.
  initial begin : sender
    int    burst_left;
    int    gap;
    beat_t b;
    for (int i = 0; i < NPROC; i++) proc_tbl[i] = '0;
    sched_running = 5'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 16);
    for (int n = 0; n < DIR_ROWS + RANDOM_BEATS; n++) begin
      if (n < DIR_ROWS) offer_beat(dir_rows[n].beat, dir_rows[n].fixed, dir_rows[n].want);
      else begin
        b = random_beat();
        offer_beat(b, 1'b0, IDLE_RES);
      end
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    while (due_decisions.size() != 0) @(posedge clk);
    // Let the block settle so that any stray result beat is still caught.
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Receiver: checks each result beat taken and drives out_stall. The stall
  // pattern switches between no stall and stalling on a
  // quarter, a half or three quarters of the cycles. Once at a fixed point,
  // and now and then at random, it holds off for a long stretch while the
  // sender keeps offering, so that the block backs up and stalls its input.
  int rx_cycle   = 0;
  int hold_left  = 0;
  int stall_mode = 0;

  task automatic take_result();
    decision_t want;
    if (due_decisions.size() == 0) begin
      report_error($sformatf("result beat with nothing expected, next_proc %0d", next_proc));
      return;
    end
    want = due_decisions.pop_front();
    if (next_proc !== want.next_proc)
      report_error($sformatf("next_proc: got %0d, expected %0d", next_proc, want.next_proc));
    if (switched !== want.switched)
      report_error($sformatf("switched: got %0b, expected %0b", switched, want.switched));
    if (new_epoch !== want.new_epoch)
      report_error($sformatf("new_epoch: got %0b, expected %0b", new_epoch, want.new_epoch));
    if (tick_budget !== want.tick_budget)
      report_error($sformatf("tick_budget: got %0d, expected %0d",
                             tick_budget, want.tick_budget));
  endtask

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (out_valid && !out_stall) take_result();
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (rx_cycle == 3000 || $urandom_range(0, 2999) == 0) begin
      out_stall <= 1'b1;
      hold_left <= 400;
    end else begin
      if (rx_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
      out_stall <= ($urandom_range(0, 3) < stall_mode);
    end
  end

  // Watchdog: a generous ceiling on the run.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

`default_nettype wire
